// ----- hw/rtl/dcmd_pkg.sv -----
// Shared types and constants for the dual-channel min/max decimator.
package dcmd_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TOTAL_W  = 32;
  localparam int LEN_W    = 8;

  localparam logic [LEN_W-1:0] WINDOW_LENGTH_RESET = 8'd25;

  localparam logic signed [SAMPLE_W-1:0] VAL_MIN = 16'sh8000;
  localparam logic signed [SAMPLE_W-1:0] VAL_MAX = 16'sh7fff;

  typedef logic signed [SAMPLE_W-1:0] sample_t;

  // One classified word as it travels from the front end to the back end.
  typedef struct packed {
    sample_t              flow;
    sample_t              pressure;
    logic                 flow_ok;
    logic                 pressure_ok;
    logic                 eob;
    logic [TOTAL_W-1:0]   total;
  } dcmd_entry_t;

endpackage

// ----- hw/rtl/dcmd_front.sv -----
// Front end: accepts input words, marks missing samples and stamps the running count.
module dcmd_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic signed [15:0]       flow_sample,
  input  logic signed [15:0]       pressure_sample,
  input  logic                     end_of_batch,
  input  logic                     q_full,
  output logic                     push,
  output dcmd_pkg::dcmd_entry_t    push_entry
);
  import dcmd_pkg::*;

  logic [TOTAL_W-1:0] total;
  logic [TOTAL_W-1:0] total_next;

  // A word is taken whenever the queue has room.
  assign in_ready   = !q_full;
  assign push       = in_valid && in_ready;
  assign total_next = total + TOTAL_W'(1);

  // Classify the word: a sample equal to the missing mark is skipped later.
  always_comb begin
    push_entry.flow        = flow_sample;
    push_entry.pressure    = pressure_sample;
    push_entry.flow_ok     = (flow_sample != VAL_MIN);
    push_entry.pressure_ok = (pressure_sample != VAL_MIN);
    push_entry.eob         = end_of_batch;
    push_entry.total       = total_next;
  end

  // The running sample count wraps naturally at its width.
  always_ff @(posedge clk) begin
    if (rst) begin
      total <= '0;
    end else if (push) begin
      total <= total_next;
    end
  end

endmodule

// ----- hw/rtl/dcmd_queue.sv -----
// Short queue of classified words between the front end and the back end.
module dcmd_queue #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  dcmd_pkg::dcmd_entry_t push_entry,
  input  logic                  pop,
  output dcmd_pkg::dcmd_entry_t head,
  output logic                  empty,
  output logic                  full,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
  import dcmd_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  dcmd_entry_t      mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;

  assign empty = (count == '0);
  assign full  = (count == CNT_W'(QUEUE_DEPTH));
  assign head  = mem[rd_ptr];

  // Storage is written only; no reset needed for the payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ----- hw/rtl/dcmd_back.sv -----
// Back end: window accumulators, window-end detection and the output register.
module dcmd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [7:0]            win_len,
  input  dcmd_pkg::dcmd_entry_t head,
  input  logic                  empty,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic signed [15:0]    flow_min,
  output logic signed [15:0]    flow_max,
  output logic signed [15:0]    pressure_min,
  output logic signed [15:0]    pressure_max,
  output logic [31:0]           samples_total
);
  import dcmd_pkg::*;

  logic [LEN_W-1:0] pos;
  sample_t          flow_low;
  sample_t          flow_high;
  sample_t          pressure_low;
  sample_t          pressure_high;

  logic [LEN_W:0]   len_ext;
  logic             win_end;
  logic             out_free;
  sample_t          flow_low_next;
  sample_t          flow_high_next;
  sample_t          pressure_low_next;
  sample_t          pressure_high_next;
  logic             flow_empty;
  logic             pressure_empty;

  // A zero length counts as 256, the wrap of the position counter.
  assign len_ext  = (win_len == '0) ? (LEN_W+1)'(256) : {1'b0, win_len};
  assign win_end  = ({1'b0, pos} + (LEN_W+1)'(1)) >= len_ext;
  assign out_free = !out_valid || out_ready;
  assign pop      = !empty && (!win_end || out_free);

  // Fold the head word into the running extremes, skipping missing samples.
  always_comb begin
    flow_low_next      = (head.flow_ok && (head.flow < flow_low)) ? head.flow : flow_low;
    flow_high_next     = (head.flow_ok && (head.flow > flow_high)) ? head.flow : flow_high;
    pressure_low_next  = (head.pressure_ok && (head.pressure < pressure_low))
                         ? head.pressure : pressure_low;
    pressure_high_next = (head.pressure_ok && (head.pressure > pressure_high))
                         ? head.pressure : pressure_high;
    flow_empty         = (flow_low_next == VAL_MAX);
    pressure_empty     = (pressure_low_next == VAL_MAX);
  end

  // Window state: cleared at window end or end of batch.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= '0;
      flow_low      <= VAL_MAX;
      flow_high     <= VAL_MIN;
      pressure_low  <= VAL_MAX;
      pressure_high <= VAL_MIN;
    end else if (pop) begin
      if (win_end || head.eob) begin
        pos           <= '0;
        flow_low      <= VAL_MAX;
        flow_high     <= VAL_MIN;
        pressure_low  <= VAL_MAX;
        pressure_high <= VAL_MIN;
      end else begin
        pos           <= pos + LEN_W'(1);
        flow_low      <= flow_low_next;
        flow_high     <= flow_high_next;
        pressure_low  <= pressure_low_next;
        pressure_high <= pressure_high_next;
      end
    end
  end

  // Output valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop && win_end) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload; an empty channel reports the missing mark for both values.
  always_ff @(posedge clk) begin
    if (pop && win_end) begin
      flow_min      <= flow_empty ? VAL_MIN : flow_low_next;
      flow_max      <= flow_empty ? VAL_MIN : flow_high_next;
      pressure_min  <= pressure_empty ? VAL_MIN : pressure_low_next;
      pressure_max  <= pressure_empty ? VAL_MIN : pressure_high_next;
      samples_total <= head.total;
    end
  end

endmodule

// ----- hw/rtl/dual_channel_minmax_decimator.sv -----
// Top level of the dual-channel min/max envelope decimator.
// The block takes one sample word per cycle while the queue has room and emits one record
// per completed window; the word that completes it passes through the word queue and then
// the output register. The front end keeps taking words while the queue has
// room (QUEUE_DEPTH words); a stalled output only holds back the back end when a window
// completes, so the sustained rate is one word per cycle while records are taken. The
// window length register has its own write channel, which is always ready. Write it only
// while no words are in flight, since words already queued see the new length at once.
module dual_channel_minmax_decimator #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         window_length,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] flow_sample,
  input  logic signed [15:0] pressure_sample,
  input  logic               end_of_batch,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] flow_min,
  output logic signed [15:0] flow_max,
  output logic signed [15:0] pressure_min,
  output logic signed [15:0] pressure_max,
  output logic [31:0]        samples_total
);
  import dcmd_pkg::*;

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [LEN_W-1:0] win_len;
  logic             push;
  dcmd_entry_t      push_entry;
  dcmd_entry_t      head;
  logic             pop;
  logic             q_empty;
  logic             q_full;
  logic [CNT_W-1:0] q_count;

  // Window length register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      win_len <= WINDOW_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      win_len <= window_length;
    end
  end

  dcmd_front u_front (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .flow_sample     (flow_sample),
    .pressure_sample (pressure_sample),
    .end_of_batch    (end_of_batch),
    .q_full          (q_full),
    .push            (push),
    .push_entry      (push_entry)
  );

  dcmd_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty),
    .full       (q_full),
    .count      (q_count)
  );

  dcmd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .win_len       (win_len),
    .head          (head),
    .empty         (q_empty),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .flow_min      (flow_min),
    .flow_max      (flow_max),
    .pressure_min  (pressure_min),
    .pressure_max  (pressure_max),
    .samples_total (samples_total)
  );

  // The queue never holds more words than it has room for.
  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= CNT_W'(QUEUE_DEPTH))
    else $error("word queue count exceeds its depth");

  // The front end only stalls when the queue is full.
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_full)
    else $error("input stalled while the queue has room");

  // A record never reports a minimum above its maximum.
  a_min_le_max: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (flow_min <= flow_max) && (pressure_min <= pressure_max))
    else $error("record minimum exceeds maximum");

  // A word enters the back end only when one is waiting in the queue.
  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_empty)
    else $error("back end took a word from an empty queue");

endmodule

// ----- tb/sv/dual_channel_minmax_decimator_tb.sv -----
// Self-checking testbench for the dual-channel min/max envelope decimator.
`timescale 1ns / 1ps

module dual_channel_minmax_decimator_tb;
  import dcmd_pkg::*;

  logic              clk             = 1'b0;
  logic              rst             = 1'b1;
  logic              cfg_valid       = 1'b0;
  logic              cfg_ready;
  logic [LEN_W-1:0]  window_length   = '0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  sample_t           flow_sample     = '0;
  sample_t           pressure_sample = '0;
  logic              end_of_batch    = 1'b0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  sample_t           flow_min;
  sample_t           flow_max;
  sample_t           pressure_min;
  sample_t           pressure_max;
  logic [TOTAL_W-1:0] samples_total;

  // When set, neither side idles or stalls.
  bit steady = 1'b0;

  // One window record as the block should emit it.
  typedef struct packed {
    sample_t            fmin;
    sample_t            fmax;
    sample_t            pmin;
    sample_t            pmax;
    logic [TOTAL_W-1:0] total;
  } envelope_t;

  // Tracks the window envelopes of both channels and holds the records still due.
  class envelope_predictor;
    envelope_t          due[$];
    int unsigned        errors;
    int unsigned        span_reg;
    int unsigned        position;
    sample_t            flow_lo, flow_hi, press_lo, press_hi;
    logic [TOTAL_W-1:0] count;

    function new();
      errors   = 0;
      span_reg = WINDOW_LENGTH_RESET;
      count    = '0;
      restart();
    endfunction

    function void restart();
      position = 0;
      flow_lo  = VAL_MAX;
      flow_hi  = VAL_MIN;
      press_lo = VAL_MAX;
      press_hi = VAL_MIN;
    endfunction

    function void set_length(logic [LEN_W-1:0] v);
      span_reg = v;
    endfunction

    function int unsigned outstanding();
      return due.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // Fold one accepted word into the window and queue a record when it closes.
    function void note_word(sample_t f, sample_t p, logic eob);
      int unsigned span;
      envelope_t   rec;
      span  = (span_reg == 0) ? 256 : span_reg;
      count = count + 1;
      if (f != VAL_MIN) begin
        if (f < flow_lo) flow_lo = f;
        if (f > flow_hi) flow_hi = f;
      end
      if (p != VAL_MIN) begin
        if (p < press_lo) press_lo = p;
        if (p > press_hi) press_hi = p;
      end
      if (position + 1 >= span) begin
        rec.fmin  = flow_lo;
        rec.fmax  = flow_hi;
        rec.pmin  = press_lo;
        rec.pmax  = press_hi;
        rec.total = count;
        // A channel whose minimum never dropped below full scale reads as empty.
        if (flow_lo == VAL_MAX) begin
          rec.fmin = VAL_MIN;
          rec.fmax = VAL_MIN;
        end
        if (press_lo == VAL_MAX) begin
          rec.pmin = VAL_MIN;
          rec.pmax = VAL_MIN;
        end
        due.push_back(rec);
        restart();
      end else begin
        position = position + 1;
      end
      if (eob) restart();
    endfunction

    // Compare one emitted record with the oldest one due.
    task check_record(sample_t fmn, sample_t fmx, sample_t pmn, sample_t pmx,
                      logic [TOTAL_W-1:0] tot);
      envelope_t want;
      if (due.size() == 0) begin
        report($sformatf("record with none due, total %0d", tot));
      end else begin
        want = due.pop_front();
        if (fmn !== want.fmin)
          report($sformatf("flow_min %0d, wanted %0d", fmn, want.fmin));
        if (fmx !== want.fmax)
          report($sformatf("flow_max %0d, wanted %0d", fmx, want.fmax));
        if (pmn !== want.pmin)
          report($sformatf("pressure_min %0d, wanted %0d", pmn, want.pmin));
        if (pmx !== want.pmax)
          report($sformatf("pressure_max %0d, wanted %0d", pmx, want.pmax));
        if (tot !== want.total)
          report($sformatf("samples_total %0d, wanted %0d", tot, want.total));
      end
    endtask
  endclass

  envelope_predictor board;

  dual_channel_minmax_decimator dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .window_length   (window_length),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .flow_sample     (flow_sample),
    .pressure_sample (pressure_sample),
    .end_of_batch    (end_of_batch),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .flow_min        (flow_min),
    .flow_max        (flow_max),
    .pressure_min    (pressure_min),
    .pressure_max    (pressure_max),
    .samples_total   (samples_total)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, and every record taken is checked.
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_ready)
      board.check_record(flow_min, flow_max, pressure_min, pressure_max, samples_total);
    out_ready <= steady ? 1'b1 : ($urandom_range(99) >= 23);
  end

  // Offer one sample word, after a random gap, and hold it until taken.
  task automatic send_word(sample_t f, sample_t p, logic eob);
    if (!steady) begin
      while ($urandom_range(99) < 23) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid        <= 1'b1;
    flow_sample     <= f;
    pressure_sample <= p;
    end_of_batch    <= eob;
    do @(posedge clk); while (!in_ready);
    board.note_word(f, p, eob);
  endtask

  // Stop sending and wait until every record due has come out.
  task automatic wait_idle(int unsigned settle);
    in_valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (settle) @(posedge clk);
  endtask

  // Write the window length while the block is idle.
  task automatic write_length(logic [LEN_W-1:0] v);
    cfg_valid     <= 1'b1;
    window_length <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    board.set_length(v);
  endtask

  function automatic sample_t rand_sample();
    case ($urandom_range(15))
      0, 1:    return VAL_MIN;
      2:       return VAL_MAX;
      3:       return -16'sd32767;
      default: return sample_t'($urandom_range(65535));
    endcase
  endfunction

  initial begin
    int unsigned spans[8];
    int unsigned words[8];
    sample_t     fv, pv;
    logic        eob;
    int          k, ph;

    board = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // A partial window under the reset length is dropped by end of batch.
    send_word(16'sd100, -16'sd100, 1'b0);
    send_word(VAL_MIN, 16'sd5, 1'b1);

    // One full window at the reset length with the sample extremes, closed
    // by a word that also carries end of batch.
    for (k = 0; k < 25; k++) begin
      case (k)
        0:       fv = VAL_MAX;
        1:       fv = -16'sd32767;
        2:       fv = 16'sd0;
        3:       fv = -16'sd1;
        4:       fv = VAL_MIN;
        default: fv = sample_t'(k * 97);
      endcase
      pv = (k < 3) ? VAL_MIN : (k == 3) ? VAL_MAX : sample_t'(-k * 131);
      send_word(fv, pv, k == 24);
    end
    wait_idle(8);

    // Single-word windows: a channel holding only full scale, and empty channels.
    write_length(8'd1);
    send_word(VAL_MAX, VAL_MIN, 1'b0);
    send_word(-16'sd32767, VAL_MAX, 1'b0);
    wait_idle(8);

    // Lower the length to the current position; the next word closes it.
    write_length(8'd3);
    send_word(16'sd10, 16'sd20, 1'b0);
    send_word(16'sd30, 16'sd40, 1'b0);
    wait_idle(8);
    write_length(8'd2);
    send_word(-16'sd5, -16'sd6, 1'b0);
    wait_idle(8);

    // Random phases; a zero length means 256 words per window.
    spans = '{1, 2, 3, $urandom_range(30, 4), 255, 0, $urandom_range(12, 1), 7};
    words = '{40, 40, 45, 45, 257, 258, 40, 35};
    for (ph = 0; ph < 8; ph++) begin
      write_length(LEN_W'(spans[ph]));
      steady <= (spans[ph] == 255);
      for (k = 0; k < words[ph]; k++) begin
        eob = (spans[ph] == 0 || spans[ph] == 255) ? 1'b0 : ($urandom_range(15) == 0);
        send_word(rand_sample(), rand_sample(), eob);
      end
      wait_idle(8);
      steady <= 1'b0;
    end

    wait_idle(20);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #200000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/dcmd_pkg.sv
hw/rtl/dcmd_front.sv
hw/rtl/dcmd_queue.sv
hw/rtl/dcmd_back.sv
hw/rtl/dual_channel_minmax_decimator.sv
tb/sv/dual_channel_minmax_decimator_tb.sv
